@@ hdl/stt_pkg.sv @@
// Shared types and constants for the soft timer table.
`default_nettype none

package stt_pkg;

   localparam int TIMER_SLOTS = 8;
   localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CMD_W       = 2;
   localparam int COUNT_W     = 16;
   localparam int ID_W        = 8;
   localparam int KIND_W      = 3;
   localparam int INDEX_W     = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_REGISTER = 2'd0,
      CMD_DELETE   = 2'd1,
      CMD_TICK     = 2'd2,
      CMD_NONE     = 2'd3
   } command_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_REGISTERED = 3'd0,
      KIND_FULL       = 3'd1,
      KIND_DELETED    = 3'd2,
      KIND_IGNORED    = 3'd3,
      KIND_EXPIRED    = 3'd4
   } event_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_WALK  = 2'd1,
      ST_FLUSH = 2'd2
   } state_type;

   typedef struct packed {
      logic do_register;
      logic do_delete;
      logic tick_start;
      logic walk_step;
      logic flush;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic pend_valid;
      logic slot_expires;
      logic walk_at_end;
   } dp_status_type;

endpackage

`default_nettype wire

@@ hdl/stt_ctrl.sv @@
// Sequencer for the soft timer table: command decode, slot walk and flush.
`default_nettype none

module stt_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic [stt_pkg::CMD_W-1:0] req_command,
   output logic                         req_ready,
   input  wire stt_pkg::dp_status_type  status,
   output stt_pkg::ctrl_cmd_type        cmd
);

   stt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         stt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (stt_pkg::command_type'(req_command))
                  stt_pkg::CMD_REGISTER: begin
                     cmd.do_register = 1'b1;
                     state_in        = stt_pkg::ST_FLUSH;
                  end
                  stt_pkg::CMD_DELETE: begin
                     cmd.do_delete = 1'b1;
                     state_in      = stt_pkg::ST_FLUSH;
                  end
                  stt_pkg::CMD_TICK: begin
                     cmd.tick_start = 1'b1;
                     state_in       = stt_pkg::ST_WALK;
                  end
                  default: begin
                     state_in = stt_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         stt_pkg::ST_WALK: begin
            // stall only when a new expiry must displace a pending one while the output register is still full
            if (!(status.slot_expires && status.pend_valid && !status.out_free)) begin
               cmd.walk_step = 1'b1;
               if (status.walk_at_end) begin
                  state_in = stt_pkg::ST_FLUSH;
               end
            end
         end
         stt_pkg::ST_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = stt_pkg::ST_IDLE;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = stt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ hdl/stt_datapath.sv @@
// Timer slot storage, slot walk arithmetic, pending result and output register.
`default_nettype none

module stt_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [stt_pkg::COUNT_W-1:0] req_start_count,
   input  wire logic [stt_pkg::COUNT_W-1:0] req_reload_period,
   input  wire logic [stt_pkg::ID_W-1:0]    req_slot_id,
   input  wire stt_pkg::ctrl_cmd_type       cmd,
   output stt_pkg::dp_status_type           status,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [stt_pkg::KIND_W-1:0]       rsp_event_kind,
   output logic [stt_pkg::INDEX_W-1:0]      rsp_timer_index,
   output logic                             rsp_last_of_run
);

   logic [stt_pkg::COUNT_W-1:0] count_ff  [stt_pkg::TIMER_SLOTS];
   logic [stt_pkg::COUNT_W-1:0] reload_ff [stt_pkg::TIMER_SLOTS];
   logic [stt_pkg::TIMER_SLOTS-1:0] in_use_ff;
   logic [stt_pkg::SLOT_W-1:0]  walk_idx_ff;

   logic                         pend_valid_ff;
   stt_pkg::event_kind_type      pend_kind_ff;
   logic [stt_pkg::INDEX_W-1:0]  pend_index_ff;

   logic                         rsp_valid_ff;
   stt_pkg::event_kind_type      rsp_kind_ff;
   logic [stt_pkg::INDEX_W-1:0]  rsp_index_ff;
   logic                         rsp_last_ff;

   logic                         free_found;
   logic [stt_pkg::SLOT_W-1:0]   free_slot;
   logic                         del_in_range;
   logic [stt_pkg::SLOT_W-1:0]   del_slot;
   logic [stt_pkg::COUNT_W-1:0]  sel_count;
   logic [stt_pkg::COUNT_W-1:0]  sel_reload;
   logic [stt_pkg::COUNT_W-1:0]  dec_count;
   logic                         expires;
   logic                         out_free;
   logic                         push_walk;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int s = stt_pkg::TIMER_SLOTS - 1; s >= 0; s--) begin
         if (!in_use_ff[s]) begin
            free_found = 1'b1;
            free_slot  = stt_pkg::SLOT_W'(s);
         end
      end
   end

   assign del_in_range = (req_slot_id < stt_pkg::ID_W'(stt_pkg::TIMER_SLOTS));
   assign del_slot     = req_slot_id[stt_pkg::SLOT_W-1:0];

   assign sel_count  = count_ff[walk_idx_ff];
   assign sel_reload = reload_ff[walk_idx_ff];
   assign dec_count  = (sel_count != '0) ? sel_count - 1'b1 : sel_count;
   assign expires    = in_use_ff[walk_idx_ff] && (dec_count == '0);

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign push_walk = cmd.walk_step && expires && pend_valid_ff;

   assign status.out_free     = out_free;
   assign status.pend_valid   = pend_valid_ff;
   assign status.slot_expires = expires;
   assign status.walk_at_end  =
      (walk_idx_ff == stt_pkg::SLOT_W'(stt_pkg::TIMER_SLOTS - 1));

   // slot payload, never read while the slot is free
   always_ff @(posedge clock) begin
      if (cmd.do_register && free_found) begin
         count_ff[free_slot]  <= req_start_count;
         reload_ff[free_slot] <= req_reload_period;
      end else if (cmd.do_delete && del_in_range) begin
         count_ff[del_slot]  <= '0;
         reload_ff[del_slot] <= '0;
      end else if (cmd.walk_step && in_use_ff[walk_idx_ff]) begin
         if (expires) begin
            count_ff[walk_idx_ff] <= sel_reload;
         end else begin
            count_ff[walk_idx_ff] <= dec_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff   <= '0;
         walk_idx_ff <= '0;
      end else begin
         if (cmd.do_register && free_found) begin
            in_use_ff[free_slot] <= 1'b1;
         end else if (cmd.do_delete && del_in_range) begin
            in_use_ff[del_slot] <= 1'b0;
         end else if (cmd.walk_step && expires && (sel_reload == '0)) begin
            in_use_ff[walk_idx_ff] <= 1'b0;
         end
         if (cmd.tick_start) begin
            walk_idx_ff <= '0;
         end else if (cmd.walk_step) begin
            walk_idx_ff <= walk_idx_ff + 1'b1;
         end
      end
   end

   // pending result: held until it is known whether it closes the run
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.do_register || cmd.do_delete
                   || (cmd.walk_step && expires)) begin
         pend_valid_ff <= 1'b1;
      end else if (cmd.flush) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_register) begin
         if (free_found) begin
            pend_kind_ff  <= stt_pkg::KIND_REGISTERED;
            pend_index_ff <= stt_pkg::INDEX_W'(free_slot);
         end else begin
            pend_kind_ff  <= stt_pkg::KIND_FULL;
            pend_index_ff <= stt_pkg::INDEX_W'(stt_pkg::TIMER_SLOTS);
         end
      end else if (cmd.do_delete) begin
         if (del_in_range) begin
            pend_kind_ff  <= stt_pkg::KIND_DELETED;
            pend_index_ff <= stt_pkg::INDEX_W'(del_slot);
         end else begin
            pend_kind_ff  <= stt_pkg::KIND_IGNORED;
            pend_index_ff <= '0;
         end
      end else if (cmd.walk_step && expires) begin
         pend_kind_ff  <= stt_pkg::KIND_EXPIRED;
         pend_index_ff <= stt_pkg::INDEX_W'(walk_idx_ff);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push_walk || cmd.flush) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push_walk || cmd.flush) begin
         rsp_kind_ff  <= pend_kind_ff;
         rsp_index_ff <= pend_index_ff;
         rsp_last_ff  <= cmd.flush;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = rsp_kind_ff;
   assign rsp_timer_index = rsp_index_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

`default_nettype wire

@@ hdl/soft_timer_table.sv @@
// A register/delete result is held in the pending register, then flushed to the
// output register; a tick walks TIMER_SLOTS slots, one per cycle unless an expiry
// finds the output register still full. One transaction at a time: a new one is taken
// only in idle, after the last result has been flushed; stalls only when a result is not taken.
// Reset: synchronous, clears all slot-in-use bits, the sequencer and valid flags;
// slot counts are loaded on register and need no clearing.
`default_nettype none

module soft_timer_table (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [stt_pkg::CMD_W-1:0]   req_command,
   input  wire logic [stt_pkg::COUNT_W-1:0] req_start_count,
   input  wire logic [stt_pkg::COUNT_W-1:0] req_reload_period,
   input  wire logic [stt_pkg::ID_W-1:0]    req_slot_id,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [stt_pkg::KIND_W-1:0]       rsp_event_kind,
   output logic [stt_pkg::INDEX_W-1:0]      rsp_timer_index,
   output logic                             rsp_last_of_run
);

   // Commands from the sequencer, status back from the datapath.
   stt_pkg::ctrl_cmd_type  cmd;
   stt_pkg::dp_status_type status;

   // Sequencer: take a transaction in idle, walk slots on tick, flush the
   // last held result with its end-of-run flag.
   stt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .status      (status),
      .cmd         (cmd)
   );

   // Datapath: slot table, decrement and reload, one held result and the
   // output register that decouples the result side.
   stt_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_start_count   (req_start_count),
      .req_reload_period (req_reload_period),
      .req_slot_id       (req_slot_id),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_timer_index   (rsp_timer_index),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

`default_nettype wire

@@ dv/soft_timer_table_tb.sv @@
// Self-checking testbench for the soft timer table: queued driver, stalling monitor, scoreboard.
`default_nettype none

module soft_timer_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import stt_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 320;
   // Cover a full slot walk plus a few receiver stalls after the last transaction.
   localparam int DRAIN_CYCLES = 4 * TIMER_SLOTS + 40;
   localparam int MAX_REPORTS  = 10;

   // One command transaction as it goes onto the request channel.
   typedef struct packed {
      command_type          cmd;
      logic [COUNT_W-1:0]   start;
      logic [COUNT_W-1:0]   period;
      logic [ID_W-1:0]      id;
   } timer_cmd_t;

   // One result transaction as the timer table should report it.
   typedef struct packed {
      event_kind_type       kind;
      logic [INDEX_W-1:0]   index;
      logic                 last;
   } timer_event_t;

   logic                 clock             = 1'b0;
   logic                 reset             = 1'b1;
   logic                 req_valid         = 1'b0;
   logic                 req_ready;
   logic [CMD_W-1:0]     req_command       = CMD_NONE;
   logic [COUNT_W-1:0]   req_start_count   = '0;
   logic [COUNT_W-1:0]   req_reload_period = '0;
   logic [ID_W-1:0]      req_slot_id       = '0;
   logic                 rsp_valid;
   logic                 rsp_ready         = 1'b0;
   logic [KIND_W-1:0]    rsp_event_kind;
   logic [INDEX_W-1:0]   rsp_timer_index;
   logic                 rsp_last_of_run;

   soft_timer_table dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_start_count   (req_start_count),
      .req_reload_period (req_reload_period),
      .req_slot_id       (req_slot_id),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_timer_index   (rsp_timer_index),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   // Commands waiting for the driver, and timer events waiting for the monitor.
   timer_cmd_t     pending_cmds[$];
   timer_event_t   timer_events_due[$];

   // Shadow copy of the timer table, advanced once per accepted command.
   logic [COUNT_W-1:0]   shadow_count  [TIMER_SLOTS];
   logic [COUNT_W-1:0]   shadow_reload [TIMER_SLOTS];
   logic                 shadow_in_use [TIMER_SLOTS];

   timer_cmd_t   in_flight;
   int           burst_left   = 1;
   int           gap_left     = 0;
   int           stall_mode   = 0;
   int           stall_window = 0;
   int           stall_left   = 0;
   int           cycle_count  = 0;
   int           mismatches   = 0;
   int           checked      = 0;
   int           n_expired    = 0;
   int           n_register   = 0;
   int           n_delete     = 0;
   int           n_tick       = 0;
   int           n_unused     = 0;

   // Free-running clock, 4 ns period.
   initial begin
      forever #2 clock = ~clock;
   end

   // Hold reset at the start, then release it for good.
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Advance the shadow table by one command and queue the timer events it causes.
   task automatic predict_timer_events(input timer_cmd_t c);
      timer_event_t   run[$];
      timer_event_t   ev;
      int             slot;
      slot = -1;
      case (c.cmd)
         CMD_REGISTER: begin
            n_register++;
            // Take the lowest free slot.
            for (int s = TIMER_SLOTS - 1; s >= 0; s--) begin
               if (!shadow_in_use[s]) slot = s;
            end
            if (slot >= 0) begin
               shadow_count[slot]  = c.start;
               shadow_reload[slot] = c.period;
               shadow_in_use[slot] = 1'b1;
               run.push_back('{KIND_REGISTERED, INDEX_W'(slot), 1'b0});
            end else begin
               run.push_back('{KIND_FULL, INDEX_W'(TIMER_SLOTS), 1'b0});
            end
         end
         CMD_DELETE: begin
            n_delete++;
            // Clear the slot even when it is already free; drop ids out of range.
            if (int'(c.id) < TIMER_SLOTS) begin
               shadow_count[c.id]  = '0;
               shadow_reload[c.id] = '0;
               shadow_in_use[c.id] = 1'b0;
               run.push_back('{KIND_DELETED, INDEX_W'(c.id), 1'b0});
            end else begin
               run.push_back('{KIND_IGNORED, INDEX_W'(0), 1'b0});
            end
         end
         CMD_TICK: begin
            n_tick++;
            // Walk the slots in use from slot 0; a zero count stays at zero and expires.
            for (int s = 0; s < TIMER_SLOTS; s++) begin
               if (shadow_in_use[s]) begin
                  if (shadow_count[s] != '0) shadow_count[s] = shadow_count[s] - 1'b1;
                  if (shadow_count[s] == '0) begin
                     run.push_back('{KIND_EXPIRED, INDEX_W'(s), 1'b0});
                     if (shadow_reload[s] != '0) begin
                        shadow_count[s] = shadow_reload[s];
                     end else begin
                        shadow_in_use[s] = 1'b0;
                        shadow_reload[s] = '0;
                     end
                  end
               end
            end
         end
         default: begin
            n_unused++;
         end
      endcase
      // Flag the final event of this command.
      if (run.size() > 0) begin
         ev = run.pop_back();
         ev.last = 1'b1;
         run.push_back(ev);
      end
      foreach (run[i]) timer_events_due.push_back(run[i]);
   endtask

   task automatic queue_cmd(input command_type cmd, input logic [COUNT_W-1:0] start,
                            input logic [COUNT_W-1:0] period, input logic [ID_W-1:0] id);
      pending_cmds.push_back('{cmd, start, period, id});
   endtask

   // Small counts so timers expire often, plus zeros, all-ones and full-range values.
   function automatic logic [COUNT_W-1:0] rand_count(input int zero_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < zero_pct) return '0;
      if (r < 70) return COUNT_W'($urandom_range(1, 4));
      if (r < 80) return '1;
      return COUNT_W'($urandom());
   endfunction

   // Driver: present one command transaction at a time, in bursts with random gaps.
   always @(posedge clock) begin : driver
      logic         hold;
      timer_cmd_t   next_cmd;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         hold = req_valid;
         if (req_valid && req_ready) begin
            predict_timer_events(in_flight);
            hold = 1'b0;
         end
         if (!hold) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_cmds.size() > 0) begin
               next_cmd          = pending_cmds.pop_front();
               in_flight         = next_cmd;
               req_command       <= next_cmd.cmd;
               req_start_count   <= next_cmd.start;
               req_reload_period <= next_cmd.period;
               req_slot_id       <= next_cmd.id;
               hold = 1'b1;
               // Close the burst and pick the next gap; a quarter of the gaps are empty.
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
         // Assign valid once per edge so back-to-back transactions keep it high.
         req_valid <= hold;
      end
   end

   // Monitor: check each accepted result against the oldest expected event, then pick ready.
   always @(posedge clock) begin : monitor
      timer_event_t   want;
      logic           take;
      if (!reset && rsp_valid && rsp_ready) begin
         if (timer_events_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("[%0d] unexpected result: kind %0d index %0d last %0d",
                        cycle_count, rsp_event_kind, rsp_timer_index, rsp_last_of_run);
         end else begin
            want = timer_events_due.pop_front();
            checked++;
            if (want.kind == KIND_EXPIRED) n_expired++;
            if (rsp_event_kind !== want.kind || rsp_timer_index !== want.index ||
                rsp_last_of_run !== want.last) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("[%0d] mismatch: expected kind %0d index %0d last %0d, ",
                           cycle_count, want.kind, want.index, want.last,
                           "got kind %0d index %0d last %0d",
                           rsp_event_kind, rsp_timer_index, rsp_last_of_run);
            end
         end
      end
      // Switch the stall pattern when the current window runs out.
      if (stall_window == 0) begin
         stall_mode   = $urandom_range(0, 3);
         stall_window = $urandom_range(20, 80);
      end else begin
         stall_window--;
      end
      case (stall_mode)
         0: take = 1'b1;
         1: take = 1'($urandom_range(0, 1));
         2: take = (cycle_count % 4 == 0);
         default: begin
            // Take one result, then hold off while the stall counter runs down.
            if (stall_left > 0) begin
               stall_left--;
               take = 1'b0;
            end else begin
               take       = 1'b1;
               stall_left = $urandom_range(0, 12);
            end
         end
      endcase
      rsp_ready <= take;
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due",
                  cycle_count, timer_events_due.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int pick;
      int useful;
      for (int s = 0; s < TIMER_SLOTS; s++) begin
         shadow_count[s]  = '0;
         shadow_reload[s] = '0;
         shadow_in_use[s] = 1'b0;
      end

      // Directed: empty table, unused command, out-of-range and free-slot deletes.
      queue_cmd(CMD_TICK, COUNT_W'($urandom()), COUNT_W'($urandom()), ID_W'($urandom()));
      queue_cmd(CMD_NONE, '1, '1, '1);
      queue_cmd(CMD_DELETE, COUNT_W'($urandom()), COUNT_W'($urandom()), ID_W'(TIMER_SLOTS));
      queue_cmd(CMD_DELETE, '0, '0, '1);
      queue_cmd(CMD_DELETE, '1, '1, ID_W'(3));
      // Fill the table: a one-shot zero count, an all-ones timer, six fast periodic ones.
      queue_cmd(CMD_REGISTER, '0, '0, '1);
      queue_cmd(CMD_REGISTER, '1, '1, '0);
      for (int s = 2; s < TIMER_SLOTS; s++)
         queue_cmd(CMD_REGISTER, COUNT_W'(1), COUNT_W'(1), ID_W'($urandom()));
      // Table full.
      queue_cmd(CMD_REGISTER, COUNT_W'(5), COUNT_W'(5), '0);
      // Zero count expires at once; periodic ones reload.
      queue_cmd(CMD_TICK, '0, '0, '0);
      queue_cmd(CMD_TICK, '1, '1, '1);
      queue_cmd(CMD_DELETE, '0, '0, ID_W'(1));
      queue_cmd(CMD_REGISTER, COUNT_W'(1), COUNT_W'(1), '0);
      queue_cmd(CMD_REGISTER, COUNT_W'(1), '0, '0);
      // Every slot expires on the same tick.
      queue_cmd(CMD_TICK, COUNT_W'($urandom()), COUNT_W'($urandom()), ID_W'($urandom()));
      queue_cmd(CMD_REGISTER, '0, '0, '0);
      queue_cmd(CMD_DELETE, '1, '0, ID_W'(TIMER_SLOTS - 1));
      queue_cmd(CMD_TICK, '0, '1, '0);

      // Random: mostly registers, deletes and ticks with sparse noise.
      useful = 0;
      while (useful < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            queue_cmd(CMD_NONE, COUNT_W'($urandom()), COUNT_W'($urandom()),
                      ID_W'($urandom()));
         end else begin
            useful++;
            if (pick < 36)
               queue_cmd(CMD_REGISTER, rand_count(15), rand_count(40), ID_W'($urandom()));
            else if (pick < 56)
               queue_cmd(CMD_DELETE, COUNT_W'($urandom()), COUNT_W'($urandom()),
                         ($urandom_range(0, 4) == 0) ? ID_W'($urandom())
                                                    : ID_W'($urandom_range(0, TIMER_SLOTS - 1)));
            else
               queue_cmd(CMD_TICK, COUNT_W'($urandom()), COUNT_W'($urandom()),
                         ID_W'($urandom()));
         end
      end

      // Drain: wait for every command and result, then let a last walk finish.
      @(negedge clock);
      while (reset || pending_cmds.size() > 0 || req_valid || timer_events_due.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (timer_events_due.size() > 0) begin
         $display("%0d expected results never arrived", timer_events_due.size());
         mismatches += timer_events_due.size();
      end
      $display("sent %0d register, %0d delete, %0d tick and %0d unused commands",
               n_register, n_delete, n_tick, n_unused);
      $display("checked %0d results (%0d expiries), %0d mismatches",
               checked, n_expired, mismatches);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
